// File: hdl/tleb_pkg.sv
// Shared constants and codes for the terminal line edit buffer.
`timescale 1ns / 1ps

package tleb_pkg;

    localparam int DEPTH  = 256;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int CHAR_W = 8;

    localparam logic [1:0] FN_CHAR  = 2'd0;
    localparam logic [1:0] FN_ENTER = 2'd1;
    localparam logic [1:0] FN_BACK  = 2'd2;
    localparam logic [1:0] FN_READ  = 2'd3;

    localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'h08;

    localparam logic [ADDR_W-1:0] LAST_SLOT = ADDR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0]  FULL_CNT  = CNT_W'(DEPTH);

    function automatic logic [ADDR_W-1:0] next_slot(input logic [ADDR_W-1:0] i);
        return (i == LAST_SLOT) ? '0 : i + ADDR_W'(1);
    endfunction

    function automatic logic [ADDR_W-1:0] prev_slot(input logic [ADDR_W-1:0] i);
        return (i == '0) ? LAST_SLOT : i - ADDR_W'(1);
    endfunction

endpackage

// File: hdl/tleb_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps

module tleb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                                     clk,
    input  logic                                     wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                         wr_data,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// File: hdl/tty_line_edit_buffer.sv
// Terminal input ring buffer with echo, backspace editing and read requests.
`timescale 1ns / 1ps

// Each request is handled in two steps: the accept cycle issues a read of the
// character store (newest entry for backspace, oldest for a read request),
// and the look state then uses the registered RAM data, updates the indices and
// loads the result register. in_ready is low in the look state, so a new
// request is taken only once the previous one has left it.
// A request is still accepted while the previous result waits in the output
// register; it then holds in the look state until that result is taken.
// No clearing pass follows reset: only written entries are ever used.
module tty_line_edit_buffer
    import tleb_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [1:0]        func,
    input  logic [CHAR_W-1:0] char_code,
    output logic              out_valid,
    input  logic              out_ready,
    output logic              echo_valid,
    output logic [CHAR_W-1:0] echo_char,
    output logic              read_valid,
    output logic [CHAR_W-1:0] read_char,
    output logic              overflow,
    output logic [CNT_W-1:0]  unread_count
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_LOOK = 1'b1;

    logic              state_reg, state_next;
    logic [ADDR_W-1:0] wr_idx_reg, wr_idx_next;
    logic [ADDR_W-1:0] rd_idx_reg, rd_idx_next;
    logic [CNT_W-1:0]  total_reg, total_next;
    logic [1:0]        func_reg;
    logic [CHAR_W-1:0] code_reg;
    logic [ADDR_W-1:0] addr_reg;
    logic              out_valid_reg, out_valid_next;

    logic              echo_valid_reg, echo_valid_next;
    logic [CHAR_W-1:0] echo_char_reg, echo_char_next;
    logic              read_valid_reg, read_valid_next;
    logic [CHAR_W-1:0] read_char_reg, read_char_next;
    logic              overflow_reg, overflow_next;

    logic              accept;
    logic              finish;
    logic              slot_free;
    logic [ADDR_W-1:0] rd_addr;
    logic [ADDR_W-1:0] issue_addr;
    logic [CHAR_W-1:0] ram_q;
    logic              ram_we;
    logic [CHAR_W-1:0] ram_wdata;

    assign in_ready  = (state_reg == ST_IDLE);
    assign accept    = in_valid && in_ready;
    assign slot_free = !out_valid_reg || out_ready;
    assign finish    = (state_reg == ST_LOOK) && slot_free;

    // backspace looks at the newest entry, everything else at the oldest
    assign issue_addr = (func == FN_BACK) ? prev_slot(wr_idx_reg) : rd_idx_reg;
    assign rd_addr    = (state_reg == ST_IDLE) ? issue_addr : addr_reg;

    assign ram_we    = finish && (func_reg == FN_CHAR || func_reg == FN_ENTER)
                       && (total_reg != FULL_CNT);
    assign ram_wdata = (func_reg == FN_ENTER) ? CH_NEWLINE : code_reg;

    tleb_ram #(
        .WIDTH (CHAR_W),
        .DEPTH (DEPTH)
    ) u_store (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (wr_idx_reg),
        .wr_data (ram_wdata),
        .rd_addr (rd_addr),
        .rd_data (ram_q)
    );

    always_comb
    begin
        state_next      = state_reg;
        wr_idx_next     = wr_idx_reg;
        rd_idx_next     = rd_idx_reg;
        total_next      = total_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        echo_valid_next = echo_valid_reg;
        echo_char_next  = echo_char_reg;
        read_valid_next = read_valid_reg;
        read_char_next  = read_char_reg;
        overflow_next   = overflow_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_LOOK;
                end
            end
            ST_LOOK:
            begin
                if (slot_free)
                begin
                    state_next      = ST_IDLE;
                    out_valid_next  = 1'b1;
                    echo_valid_next = 1'b0;
                    echo_char_next  = '0;
                    read_valid_next = 1'b0;
                    read_char_next  = '0;
                    overflow_next   = 1'b0;
                    unique case (func_reg)
                        FN_CHAR, FN_ENTER:
                        begin
                            if (total_reg == FULL_CNT)
                            begin
                                overflow_next = 1'b1;
                            end
                            else
                            begin
                                wr_idx_next     = next_slot(wr_idx_reg);
                                total_next      = total_reg + CNT_W'(1);
                                echo_valid_next = 1'b1;
                                echo_char_next  = ram_wdata;
                            end
                        end
                        FN_BACK:
                        begin
                            // a newline closes the line; it cannot be erased
                            if (total_reg != '0 && ram_q != CH_NEWLINE)
                            begin
                                wr_idx_next     = addr_reg;
                                total_next      = total_reg - CNT_W'(1);
                                echo_valid_next = 1'b1;
                                echo_char_next  = CH_BACKSPACE;
                            end
                        end
                        default:
                        begin
                            if (total_reg != '0)
                            begin
                                read_valid_next = 1'b1;
                                read_char_next  = ram_q;
                                rd_idx_next     = next_slot(rd_idx_reg);
                                total_next      = total_reg - CNT_W'(1);
                            end
                        end
                    endcase
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            wr_idx_reg    <= '0;
            rd_idx_reg    <= '0;
            total_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            wr_idx_reg    <= wr_idx_next;
            rd_idx_reg    <= rd_idx_next;
            total_reg     <= total_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            func_reg <= func;
            code_reg <= char_code;
            addr_reg <= issue_addr;
        end
        echo_valid_reg <= echo_valid_next;
        echo_char_reg  <= echo_char_next;
        read_valid_reg <= read_valid_next;
        read_char_reg  <= read_char_next;
        overflow_reg   <= overflow_next;
    end

    assign out_valid    = out_valid_reg;
    assign echo_valid   = echo_valid_reg;
    assign echo_char    = echo_char_reg;
    assign read_valid   = read_valid_reg;
    assign read_char    = read_char_reg;
    assign overflow     = overflow_reg;
    assign unread_count = total_reg;

endmodule

// File: verif/tb_top.sv
// Testbench for the terminal line edit buffer: key driver, reply monitor and scoreboard.
`timescale 1ns / 1ps

module tb_top;
    import tleb_pkg::*;

    localparam int IDLE_LIMIT = 4000;

    typedef struct packed {
        logic [1:0]        func;
        logic [CHAR_W-1:0] code;
    } key_req_t;

    typedef struct packed {
        logic              echo_valid;
        logic [CHAR_W-1:0] echo_char;
        logic              read_valid;
        logic [CHAR_W-1:0] read_char;
        logic              overflow;
        logic [CNT_W-1:0]  unread_count;
    } line_reply_t;

    logic              clk = 1'b1;
    logic              rst_n = 1'b0;
    logic              in_valid = 1'b0;
    logic              in_ready;
    logic [1:0]        func = FN_READ;
    logic [CHAR_W-1:0] char_code = '0;
    logic              out_valid;
    logic              out_ready = 1'b0;
    logic              echo_valid;
    logic [CHAR_W-1:0] echo_char;
    logic              read_valid;
    logic [CHAR_W-1:0] read_char;
    logic              overflow;
    logic [CNT_W-1:0]  unread_count;

    key_req_t    pending_keys[$];
    line_reply_t expected_replies[$];

    // shadow copy of the line buffer
    logic [CHAR_W-1:0] shadow_store [DEPTH];
    logic [ADDR_W-1:0] wr_slot = '0;
    logic [ADDR_W-1:0] rd_slot = '0;
    int                held = 0;

    int       mismatches = 0;
    int       idle_cycles = 0;
    logic     in_fire = 1'b0;
    logic     out_fire = 1'b0;
    int       in_wait = 0;
    int       out_wait = 0;
    bit       in_calm = 1'b0;
    bit       out_calm = 1'b0;
    key_req_t next_key;

    tty_line_edit_buffer dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .func         (func),
        .char_code    (char_code),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .echo_valid   (echo_valid),
        .echo_char    (echo_char),
        .read_valid   (read_valid),
        .read_char    (read_char),
        .overflow     (overflow),
        .unread_count (unread_count)
    );

    always
    begin
        #6 clk = 1'b0;
        #6 clk = 1'b1;
    end

    function automatic line_reply_t edit_line(input logic [1:0] f, input logic [CHAR_W-1:0] code);
        line_reply_t       r;
        logic [CHAR_W-1:0] c;
        logic [ADDR_W-1:0] last;
        r = '0;
        case (f)
            FN_CHAR, FN_ENTER:
            begin
                c = (f == FN_ENTER) ? CH_NEWLINE : code;
                if (held >= DEPTH)
                    r.overflow = 1'b1;
                else
                begin
                    shadow_store[wr_slot] = c;
                    wr_slot = next_slot(wr_slot);
                    held++;
                    r.echo_valid = 1'b1;
                    r.echo_char = c;
                end
            end
            FN_BACK:
            begin
                last = prev_slot(wr_slot);
                // a newline closes the line; it cannot be erased
                if (held > 0 && shadow_store[last] != CH_NEWLINE)
                begin
                    wr_slot = last;
                    held--;
                    r.echo_valid = 1'b1;
                    r.echo_char = CH_BACKSPACE;
                end
            end
            default:
            begin
                if (held > 0)
                begin
                    r.read_valid = 1'b1;
                    r.read_char = shadow_store[rd_slot];
                    rd_slot = next_slot(rd_slot);
                    held--;
                end
            end
        endcase
        r.unread_count = CNT_W'(held);
        return r;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
        if (want !== got)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("%0t: %s expected %0h got %0h", $time, name, want, got);
        end
    endtask

    task automatic push_key(input logic [1:0] f, input logic [CHAR_W-1:0] code);
        key_req_t k;
        k.func = f;
        k.code = code;
        pending_keys.push_back(k);
    endtask

    function automatic logic [CHAR_W-1:0] any_code();
        return CHAR_W'($urandom_range(0, 255));
    endfunction

    // edge cases first: empty store, literal newline and backspace codes, drain past empty
    task automatic add_directed_keys();
        push_key(FN_READ, 8'hFF);
        push_key(FN_BACK, 8'h00);
        push_key(FN_CHAR, 8'h00);
        push_key(FN_CHAR, 8'hFF);
        push_key(FN_BACK, 8'h55);
        push_key(FN_CHAR, CH_NEWLINE);
        push_key(FN_BACK, 8'h00);
        push_key(FN_ENTER, 8'hFF);
        push_key(FN_BACK, 8'hAA);
        push_key(FN_CHAR, CH_BACKSPACE);
        push_key(FN_BACK, 8'hFF);
        push_key(FN_CHAR, 8'h55);
        push_key(FN_CHAR, 8'hAA);
        repeat (6) push_key(FN_READ, any_code());
    endtask

    task automatic add_random_keys(input int target);
        int made;
        int kind;
        int n;
        int pick;
        made = 0;
        kind = 3;  // start with a flood so the full store is hit early
        while (made < target)
        begin
            case (kind)
                0:
                begin
                    n = $urandom_range(1, 40);
                    for (int i = 0; i < n; i++)
                    begin
                        if ($urandom_range(0, 7) == 0)
                            push_key(FN_BACK, any_code());
                        else if ($urandom_range(0, 3) == 0)
                            push_key(FN_CHAR, any_code());
                        else
                            push_key(FN_CHAR, CHAR_W'($urandom_range(8'h20, 8'h7E)));
                    end
                    if ($urandom_range(0, 3) != 0)
                    begin
                        push_key(FN_ENTER, any_code());
                        n++;
                    end
                end
                1:
                begin
                    n = $urandom_range(1, 50);
                    repeat (n) push_key(FN_READ, any_code());
                end
                2:
                begin
                    n = $urandom_range(1, 20);
                    repeat (n) push_key(2'($urandom_range(0, 3)), any_code());
                end
                default:
                begin
                    n = $urandom_range(DEPTH + 4, DEPTH + 40);
                    repeat (n) push_key(FN_CHAR, any_code());
                end
            endcase
            made += n;
            pick = $urandom_range(0, 99);
            kind = (pick < 45) ? 0 : (pick < 80) ? 1 : (pick < 98) ? 2 : 3;
        end
    endtask

    // prediction on each accepted request
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            in_fire <= in_valid && in_ready;
            if (in_valid && in_ready)
                expected_replies.push_back(edit_line(func, char_code));
        end
    end

    // reply checking
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            out_fire <= out_valid && out_ready;
            if (out_valid && out_ready)
            begin
                if (expected_replies.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: reply with no request outstanding", $time);
                end
                else
                begin
                    line_reply_t e;
                    e = expected_replies.pop_front();
                    check_field("echo_valid", 32'(e.echo_valid), 32'(echo_valid));
                    check_field("echo_char", 32'(e.echo_char), 32'(echo_char));
                    check_field("read_valid", 32'(e.read_valid), 32'(read_valid));
                    check_field("read_char", 32'(e.read_char), 32'(read_char));
                    check_field("overflow", 32'(e.overflow), 32'(overflow));
                    check_field("unread_count", 32'(e.unread_count), 32'(unread_count));
                end
            end
        end
    end

    // key driver
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (in_fire)
            begin
                if ($urandom_range(0, 63) == 0)
                    in_calm = !in_calm;
                in_wait = in_calm ? 0 : $urandom_range(0, 17);
            end
            if (in_valid && !in_fire)
            begin
                // hold until taken
            end
            else if (in_wait > 0)
            begin
                in_valid <= 1'b0;
                in_wait--;
            end
            else if (pending_keys.size() > 0)
            begin
                next_key = pending_keys.pop_front();
                in_valid <= 1'b1;
                func <= next_key.func;
                char_code <= next_key.code;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // reply side backpressure
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (out_fire)
            begin
                if ($urandom_range(0, 63) == 0)
                    out_calm = !out_calm;
                out_wait = out_calm ? 0 : $urandom_range(0, 17);
            end
            if (out_wait > 0)
            begin
                out_ready <= 1'b0;
                out_wait--;
            end
            else
                out_ready <= 1'b1;
        end
    end

    // watchdog: only counts while work is outstanding
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else if (pending_keys.size() > 0 || in_valid || expected_replies.size() > 0)
        begin
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("tty_line_edit_buffer: mismatch");
                $finish;
            end
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    initial
    begin
        add_directed_keys();
        add_random_keys(1950);
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        while (pending_keys.size() > 0 || in_valid || expected_replies.size() > 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (mismatches == 0 && expected_replies.size() == 0)
            $display("tty_line_edit_buffer: match");
        else
            $display("tty_line_edit_buffer: mismatch");
        $finish;
    end

endmodule
